FILE: design/jtv_pkg.sv
package jtv_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES      = 24;

   localparam int ANGLE_W = 19;
   localparam int RATE_W  = 19;
   localparam int LEN_W   = 17;
   localparam int LIN_W   = 24;
   localparam int ANG_W   = 21;
   localparam int NUM_JOINTS = 6;
   localparam int NUM_REGS   = 6;

   localparam int PHASE_W = ANGLE_W + 2;
   localparam int CW      = 32;
   localparam int TRIG_W  = 18;
   localparam int MUL_W   = 2 * TRIG_W;
   localparam int EW      = TRIG_W + 1;
   localparam int LW      = 38;
   localparam int LJ_W    = TRIG_W + LW;
   localparam int JA_W    = 19;
   localparam int PL_W    = LW + RATE_W;
   localparam int PA_W    = JA_W + RATE_W;
   localparam int ACC_L_W = PL_W + 3;
   localparam int ACC_A_W = PA_W + 3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [CW-1:0] PI_Q28          = 32'sd843314857;
   localparam logic signed [CW-1:0] TWO_PI_Q28      = 32'sd1686629713;
   localparam logic signed [CW-1:0] HALF_PI_Q28     = 32'sd421657428;
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q28 = 32'sd163008219;
   localparam logic signed [JA_W-1:0] ONE_Q16       = 19'sd65536;

   localparam logic signed [LEN_W-1:0] UPPER_ARM_RESET = -17'sd15594;
   localparam logic signed [LEN_W-1:0] FOREARM_RESET   = -17'sd13632;
   localparam logic signed [LEN_W-1:0] SHOULDER_RESET  = 17'sd7670;
   localparam logic signed [LEN_W-1:0] WRIST_ONE_RESET = -17'sd605;
   localparam logic signed [LEN_W-1:0] WRIST_TWO_RESET = 17'sd5338;
   localparam logic signed [LEN_W-1:0] FLANGE_RESET    = 17'sd5274;

   typedef enum logic [2:0] {
      REG_UPPER_ARM = 3'd0,
      REG_FOREARM   = 3'd1,
      REG_SHOULDER  = 3'd2,
      REG_WRIST_ONE = 3'd3,
      REG_WRIST_TWO = 3'd4,
      REG_FLANGE    = 3'd5
   } csr_index_type;

   function automatic int cordic_iters(input int n);
      return (n > ATAN_ENTRIES) ? ATAN_ENTRIES : n;
   endfunction

   // reduce, wrap, fold, iterations, round
   function automatic int cordic_depth(input int n);
      return cordic_iters(n) + 4;
   endfunction

   function automatic logic signed [CW-1:0] atan_q28(input int i);
      case (i)
         0:  return 32'sd210828714;
         1:  return 32'sd124459457;
         2:  return 32'sd65760959;
         3:  return 32'sd33381290;
         4:  return 32'sd16755422;
         5:  return 32'sd8385879;
         6:  return 32'sd4193963;
         7:  return 32'sd2097109;
         8:  return 32'sd1048571;
         9:  return 32'sd524287;
         10: return 32'sd262144;
         11: return 32'sd131072;
         12: return 32'sd65536;
         13: return 32'sd32768;
         14: return 32'sd16384;
         15: return 32'sd8192;
         16: return 32'sd4096;
         17: return 32'sd2048;
         18: return 32'sd1024;
         19: return 32'sd512;
         20: return 32'sd256;
         21: return 32'sd128;
         22: return 32'sd64;
         23: return 32'sd32;
         default: return '0;
      endcase
   endfunction

   // product of two Q16 trig values, rounded back to Q16
   function automatic logic signed [TRIG_W-1:0] mul16(input logic signed [TRIG_W-1:0] a,
                                                      input logic signed [TRIG_W-1:0] b);
      logic signed [MUL_W-1:0] p;
      p = MUL_W'(a) * MUL_W'(b);
      p = p + MUL_W'(32768);
      p = p >>> 16;
      return p[TRIG_W-1:0];
   endfunction

   // Q16 trig times Q22 length sum, rounded back to Q22
   function automatic logic signed [LW-1:0] lmul16(input logic signed [TRIG_W-1:0] t,
                                                   input logic signed [LW-1:0] l);
      logic signed [LJ_W-1:0] p;
      p = LJ_W'(t) * LJ_W'(l);
      p = p + LJ_W'(32768);
      p = p >>> 16;
      return p[LW-1:0];
   endfunction

endpackage

FILE: design/jtv_if.sv
interface jtv_req_if import jtv_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [ANGLE_W-1:0] joint1_angle;
   logic signed [ANGLE_W-1:0] joint2_angle;
   logic signed [ANGLE_W-1:0] joint3_angle;
   logic signed [ANGLE_W-1:0] joint4_angle;
   logic signed [ANGLE_W-1:0] joint5_angle;
   logic signed [ANGLE_W-1:0] joint6_angle;
   logic signed [RATE_W-1:0]  joint1_rate;
   logic signed [RATE_W-1:0]  joint2_rate;
   logic signed [RATE_W-1:0]  joint3_rate;
   logic signed [RATE_W-1:0]  joint4_rate;
   logic signed [RATE_W-1:0]  joint5_rate;
   logic signed [RATE_W-1:0]  joint6_rate;

   modport source (output valid, joint1_angle, joint2_angle, joint3_angle, joint4_angle,
                   joint5_angle, joint6_angle, joint1_rate, joint2_rate, joint3_rate,
                   joint4_rate, joint5_rate, joint6_rate, input ready);
   modport sink (input valid, joint1_angle, joint2_angle, joint3_angle, joint4_angle,
                 joint5_angle, joint6_angle, joint1_rate, joint2_rate, joint3_rate,
                 joint4_rate, joint5_rate, joint6_rate, output ready);
endinterface

interface jtv_rsp_if import jtv_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [LIN_W-1:0] linear_x;
   logic signed [LIN_W-1:0] linear_y;
   logic signed [LIN_W-1:0] linear_z;
   logic signed [ANG_W-1:0] angular_x;
   logic signed [ANG_W-1:0] angular_y;
   logic signed [ANG_W-1:0] angular_z;

   modport source (output valid, linear_x, linear_y, linear_z, angular_x, angular_y,
                   angular_z, input ready);
   modport sink (input valid, linear_x, linear_y, linear_z, angular_x, angular_y,
                 angular_z, output ready);
endinterface

FILE: design/jtv_cordic.sv
module jtv_cordic import jtv_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                                    clock,
   input  logic [cordic_depth(CORDIC_STAGES)-1:0]  load,
   input  logic signed [PHASE_W-1:0]               phase,
   output logic signed [TRIG_W-1:0]                sin_out,
   output logic signed [TRIG_W-1:0]                cos_out
);

   localparam int NS     = cordic_iters(CORDIC_STAGES);
   localparam int RW     = PHASE_W + 14;
   localparam int RED1_W = 33;
   localparam int RED2_W = 31;
   localparam logic [RW-1:0]     TP4 = RW'(TWO_PI_Q28) << 2;
   localparam logic [RED1_W-1:0] TP2 = RED1_W'(TWO_PI_Q28) << 1;
   localparam logic [RED1_W-1:0] TP1 = RED1_W'(TWO_PI_Q28);

   // reduction: magnitude mod 2*pi by restoring subtraction, quotient below eight
   logic signed [RW-1:0]   wide;
   logic [RW-1:0]          mag;
   logic [RED1_W-1:0]      red1_in, red1_ff, red1b;
   logic                   sign1_ff, sign2_ff;
   logic [RED2_W-1:0]      red2_in, red2_ff;
   logic signed [CW-1:0]   z0_in, z0_ff, rs;
   logic                   neg0_in, neg0_ff;

   always_comb begin
      wide = RW'(phase) <<< 14;
      mag  = phase[PHASE_W-1] ? RW'(-wide) : RW'(wide);
      red1_in = (mag >= TP4) ? RED1_W'(mag - TP4) : RED1_W'(mag);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         red1_ff  <= red1_in;
         sign1_ff <= phase[PHASE_W-1];
      end
   end

   always_comb begin
      red1b   = (red1_ff >= TP2) ? (red1_ff - TP2) : red1_ff;
      red2_in = (red1b >= TP1) ? RED2_W'(red1b - TP1) : RED2_W'(red1b);
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         red2_ff  <= red2_in;
         sign2_ff <= sign1_ff;
      end
   end

   always_comb begin
      rs = sign2_ff ? -CW'({1'b0, red2_ff}) : CW'({1'b0, red2_ff});
      if (rs > PI_Q28) begin
         rs = rs - TWO_PI_Q28;
      end else if (rs < -PI_Q28) begin
         rs = rs + TWO_PI_Q28;
      end
      neg0_in = 1'b0;
      z0_in   = rs;
      if (rs > HALF_PI_Q28) begin
         z0_in   = PI_Q28 - rs;
         neg0_in = 1'b1;
      end else if (rs < -HALF_PI_Q28) begin
         z0_in   = -PI_Q28 - rs;
         neg0_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         z0_ff   <= z0_in;
         neg0_ff <= neg0_in;
      end
   end

   logic signed [CW-1:0] x_ff [NS];
   logic signed [CW-1:0] y_ff [NS];
   logic signed [CW-1:0] z_ff [NS];
   logic                 neg_ff [NS];

   for (genvar i = 0; i < NS; i++) begin : g_iter
      logic signed [CW-1:0] xp, yp, zp, x_in, y_in, z_in;
      logic                 np;
      if (i == 0) begin : g_first
         assign xp = CORDIC_GAIN_Q28;
         assign yp = '0;
         assign zp = z0_ff;
         assign np = neg0_ff;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign np = neg_ff[i-1];
      end

      always_comb begin
         if (!zp[CW-1]) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - atan_q28(i);
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + atan_q28(i);
         end
      end

      always_ff @(posedge clock) begin
         if (load[3+i]) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            neg_ff[i] <= np;
         end
      end
   end

   logic signed [CW-1:0]     xr, yr;
   logic signed [TRIG_W-1:0] sin_in, cos_in, sin_ff, cos_ff;

   always_comb begin
      xr     = (x_ff[NS-1] + CW'(2048)) >>> 12;
      yr     = (y_ff[NS-1] + CW'(2048)) >>> 12;
      sin_in = yr[TRIG_W-1:0];
      cos_in = neg_ff[NS-1] ? -xr[TRIG_W-1:0] : xr[TRIG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load[NS+3]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

FILE: design/jacobian_tool_velocity_core.sv
// tool velocity from joint state: closed-form 6x6 jacobian times the joint rates
// throughput: one item per cycle while the output is not stalled; the cordic and
// multiply-add stages are fully pipelined
// a stalled output holds the last stage, upstream bubbles still close up behind it
// reset (synchronous, active high) empties the pipeline and reloads the link lengths
module jacobian_tool_velocity_core import jtv_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   jtv_req_if.sink                req,
   jtv_rsp_if.source              rsp,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int CD   = cordic_depth(CORDIC_STAGES);
   localparam int SA   = CD + 1;
   localparam int SB   = CD + 2;
   localparam int SC   = CD + 3;
   localparam int SD   = CD + 4;
   localparam int SE   = CD + 5;
   localparam int SF   = CD + 6;
   localparam int SG   = CD + 7;
   localparam int NSTG = CD + 8;

   // ---------------- configuration registers
   logic signed [LEN_W-1:0] len_ff [NUM_REGS];
   logic signed [LEN_W-1:0] len_in [NUM_REGS];
   csr_index_type           csr_idx;
   logic                    csr_we;

   assign csr_idx    = csr_index_type'(csr_paddr[4:2]);
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      len_in = len_ff;
      csr_prdata = '0;
      case (csr_idx)
         REG_UPPER_ARM, REG_FOREARM, REG_SHOULDER, REG_WRIST_ONE, REG_WRIST_TWO,
         REG_FLANGE: begin
            if (csr_we) begin
               len_in[csr_idx] = csr_pwdata[LEN_W-1:0];
            end
            csr_prdata = {{(CSR_DATA_W-LEN_W){len_ff[csr_idx][LEN_W-1]}}, len_ff[csr_idx]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff[REG_UPPER_ARM] <= UPPER_ARM_RESET;
         len_ff[REG_FOREARM]   <= FOREARM_RESET;
         len_ff[REG_SHOULDER]  <= SHOULDER_RESET;
         len_ff[REG_WRIST_ONE] <= WRIST_ONE_RESET;
         len_ff[REG_WRIST_TWO] <= WRIST_TWO_RESET;
         len_ff[REG_FLANGE]    <= FLANGE_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   logic signed [LEN_W-1:0] a2, a3, d5, d6;
   logic signed [LEN_W:0]   d24;
   assign a2  = len_ff[REG_UPPER_ARM];
   assign a3  = len_ff[REG_FOREARM];
   assign d5  = len_ff[REG_WRIST_TWO];
   assign d6  = len_ff[REG_FLANGE];
   assign d24 = (LEN_W+1)'(len_ff[REG_SHOULDER]) + (LEN_W+1)'(len_ff[REG_WRIST_ONE]);

   // ---------------- pipeline flow control
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] load;

   assign load[NSTG-1] = !valid_ff[NSTG-1] || rsp.ready;
   for (genvar i = 0; i < NSTG - 1; i++) begin : g_load
      assign load[i] = !valid_ff[i] || load[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (load[i]) begin
               valid_ff[i] <= (i == 0) ? req.valid : valid_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req.ready = load[0];

   // ---------------- input stage and rate delay line
   logic signed [ANGLE_W-1:0] q_ff [5];
   logic signed [RATE_W-1:0]  wp_ff [SE][NUM_JOINTS];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         q_ff[0] <= req.joint1_angle;
         q_ff[1] <= req.joint2_angle;
         q_ff[2] <= req.joint3_angle;
         q_ff[3] <= req.joint4_angle;
         q_ff[4] <= req.joint5_angle;
         wp_ff[0][0] <= req.joint1_rate;
         wp_ff[0][1] <= req.joint2_rate;
         wp_ff[0][2] <= req.joint3_rate;
         wp_ff[0][3] <= req.joint4_rate;
         wp_ff[0][4] <= req.joint5_rate;
         wp_ff[0][5] <= req.joint6_rate;
      end
   end

   for (genvar i = 1; i < SE; i++) begin : g_wpipe
      always_ff @(posedge clock) begin
         if (load[i]) begin
            wp_ff[i] <= wp_ff[i-1];
         end
      end
   end

   // ---------------- sines and cosines: q0, q1, q1+q2, q1+q2+q3, q4
   logic signed [PHASE_W-1:0] phase [5];
   logic signed [TRIG_W-1:0]  sin_w [5];
   logic signed [TRIG_W-1:0]  cos_w [5];

   assign phase[0] = PHASE_W'(q_ff[0]);
   assign phase[1] = PHASE_W'(q_ff[1]);
   assign phase[2] = PHASE_W'(q_ff[1]) + PHASE_W'(q_ff[2]);
   assign phase[3] = PHASE_W'(q_ff[1]) + PHASE_W'(q_ff[2]) + PHASE_W'(q_ff[3]);
   assign phase[4] = PHASE_W'(q_ff[4]);

   for (genvar k = 0; k < 5; k++) begin : g_trig
      jtv_cordic #(
         .CORDIC_STAGES(CORDIC_STAGES)
      ) u_cordic (
         .clock   (clock),
         .load    (load[CD:1]),
         .phase   (phase[k]),
         .sin_out (sin_w[k]),
         .cos_out (cos_w[k])
      );
   end

   // ---------------- stage A: trig products
   typedef struct packed {
      logic signed [TRIG_W-1:0] s0, c0, s1, c1, s12, c12, s123, c123;
      logic signed [TRIG_W-1:0] s0s4, c0c4, c0s4, c4s0, s123s4, c123s4, s123c4;
      logic signed [TRIG_W-1:0] c12s0, c1s0, s123s0, c12c0, c1c0, s123c0;
   } stage_a_type;

   stage_a_type sta_in, sta_ff;

   always_comb begin
      sta_in.s0     = sin_w[0];
      sta_in.c0     = cos_w[0];
      sta_in.s1     = sin_w[1];
      sta_in.c1     = cos_w[1];
      sta_in.s12    = sin_w[2];
      sta_in.c12    = cos_w[2];
      sta_in.s123   = sin_w[3];
      sta_in.c123   = cos_w[3];
      sta_in.s0s4   = mul16(sin_w[0], sin_w[4]);
      sta_in.c0c4   = mul16(cos_w[0], cos_w[4]);
      sta_in.c0s4   = mul16(cos_w[0], sin_w[4]);
      sta_in.c4s0   = mul16(cos_w[4], sin_w[0]);
      sta_in.s123s4 = mul16(sin_w[3], sin_w[4]);
      sta_in.c123s4 = mul16(cos_w[3], sin_w[4]);
      sta_in.s123c4 = mul16(sin_w[3], cos_w[4]);
      sta_in.c12s0  = mul16(cos_w[2], sin_w[0]);
      sta_in.c1s0   = mul16(cos_w[1], sin_w[0]);
      sta_in.s123s0 = mul16(sin_w[3], sin_w[0]);
      sta_in.c12c0  = mul16(cos_w[2], cos_w[0]);
      sta_in.c1c0   = mul16(cos_w[1], cos_w[0]);
      sta_in.s123c0 = mul16(sin_w[3], cos_w[0]);
   end

   always_ff @(posedge clock) begin
      if (load[SA]) begin
         sta_ff <= sta_in;
      end
   end

   // ---------------- stage B: second trig products and length products
   typedef struct packed {
      logic signed [TRIG_W-1:0] s0, c0, c123, s123c0, s123s0, s123s4;
      logic signed [TRIG_W-1:0] c0c4, c4s0, s0s4, c0s4, m1, m2, m3, m4;
      logic signed [LW-1:0] a3s12, a2s1, d5c123, d6s123s4, a3c12, a2c1, d5s123;
      logic signed [LW-1:0] d6c123s4, d6s123c4, d24c0, d24s0;
      logic signed [LW-1:0] a3c12s0, a2c1s0, d5s123s0, a3c12c0, a2c1c0, d5s123c0;
   } stage_b_type;

   stage_b_type stb_in, stb_ff;

   always_comb begin
      stb_in.s0       = sta_ff.s0;
      stb_in.c0       = sta_ff.c0;
      stb_in.c123     = sta_ff.c123;
      stb_in.s123c0   = sta_ff.s123c0;
      stb_in.s123s0   = sta_ff.s123s0;
      stb_in.s123s4   = sta_ff.s123s4;
      stb_in.c0c4     = sta_ff.c0c4;
      stb_in.c4s0     = sta_ff.c4s0;
      stb_in.s0s4     = sta_ff.s0s4;
      stb_in.c0s4     = sta_ff.c0s4;
      stb_in.m1       = mul16(sta_ff.c123, sta_ff.s0s4);
      stb_in.m2       = mul16(sta_ff.c123, sta_ff.c0s4);
      stb_in.m3       = mul16(sta_ff.c123, sta_ff.c0c4);
      stb_in.m4       = mul16(sta_ff.c123, sta_ff.c4s0);
      stb_in.a3s12    = LW'(a3) * LW'(sta_ff.s12);
      stb_in.a2s1     = LW'(a2) * LW'(sta_ff.s1);
      stb_in.d5c123   = LW'(d5) * LW'(sta_ff.c123);
      stb_in.d6s123s4 = LW'(d6) * LW'(sta_ff.s123s4);
      stb_in.a3c12    = LW'(a3) * LW'(sta_ff.c12);
      stb_in.a2c1     = LW'(a2) * LW'(sta_ff.c1);
      stb_in.d5s123   = LW'(d5) * LW'(sta_ff.s123);
      stb_in.d6c123s4 = LW'(d6) * LW'(sta_ff.c123s4);
      stb_in.d6s123c4 = LW'(d6) * LW'(sta_ff.s123c4);
      stb_in.d24c0    = LW'(d24) * LW'(sta_ff.c0);
      stb_in.d24s0    = LW'(d24) * LW'(sta_ff.s0);
      stb_in.a3c12s0  = LW'(a3) * LW'(sta_ff.c12s0);
      stb_in.a2c1s0   = LW'(a2) * LW'(sta_ff.c1s0);
      stb_in.d5s123s0 = LW'(d5) * LW'(sta_ff.s123s0);
      stb_in.a3c12c0  = LW'(a3) * LW'(sta_ff.c12c0);
      stb_in.a2c1c0   = LW'(a2) * LW'(sta_ff.c1c0);
      stb_in.d5s123c0 = LW'(d5) * LW'(sta_ff.s123c0);
   end

   always_ff @(posedge clock) begin
      if (load[SB]) begin
         stb_ff <= stb_in;
      end
   end

   // ---------------- stage C: sums
   typedef struct packed {
      logic signed [TRIG_W-1:0] s0, c0, c123, s123c0, s123s0, s123s4;
      logic signed [EW-1:0]     e00, e10, e04, e14;
      logic signed [LW-1:0]     w, v, u, j21, j22, j23, j24, part0, part1;
   } stage_c_type;

   stage_c_type stc_in, stc_ff;

   always_comb begin
      stc_in.s0     = stb_ff.s0;
      stc_in.c0     = stb_ff.c0;
      stc_in.c123   = stb_ff.c123;
      stc_in.s123c0 = stb_ff.s123c0;
      stc_in.s123s0 = stb_ff.s123s0;
      stc_in.s123s4 = stb_ff.s123s4;
      stc_in.e00 = EW'(stb_ff.c0c4) + EW'(stb_ff.m1);
      stc_in.e10 = EW'(stb_ff.c4s0) - EW'(stb_ff.m2);
      stc_in.e04 = EW'(stb_ff.s0s4) + EW'(stb_ff.m3);
      stc_in.e14 = EW'(stb_ff.c0s4) - EW'(stb_ff.m4);
      stc_in.w   = stb_ff.a3s12 + stb_ff.a2s1 - stb_ff.d5c123 - stb_ff.d6s123s4;
      stc_in.v   = stb_ff.d5c123 - stb_ff.a3s12 + stb_ff.d6s123s4;
      stc_in.u   = stb_ff.d5c123 + stb_ff.d6s123s4;
      stc_in.j21 = stb_ff.a3c12 + stb_ff.a2c1 + stb_ff.d5s123 - stb_ff.d6c123s4;
      stc_in.j22 = stb_ff.a3c12 + stb_ff.d5s123 - stb_ff.d6c123s4;
      stc_in.j23 = stb_ff.d5s123 - stb_ff.d6c123s4;
      stc_in.j24 = -stb_ff.d6s123c4;
      stc_in.part0 = stb_ff.d24c0 - stb_ff.a3c12s0 - stb_ff.a2c1s0 - stb_ff.d5s123s0;
      stc_in.part1 = stb_ff.d24s0 + stb_ff.a3c12c0 + stb_ff.a2c1c0 + stb_ff.d5s123c0;
   end

   always_ff @(posedge clock) begin
      if (load[SC]) begin
         stc_ff <= stc_in;
      end
   end

   // ---------------- stage D: jacobian entries
   logic signed [LW-1:0]   jl_in [3][NUM_JOINTS];
   logic signed [LW-1:0]   jl_ff [3][NUM_JOINTS];
   logic signed [JA_W-1:0] ja_in [3][NUM_JOINTS];
   logic signed [JA_W-1:0] ja_ff [3][NUM_JOINTS];

   always_comb begin
      jl_in[0][0] = LW'(d6) * LW'(stc_ff.e00) + stc_ff.part0;
      jl_in[1][0] = LW'(d6) * LW'(stc_ff.e10) + stc_ff.part1;
      jl_in[2][0] = '0;
      jl_in[0][1] = lmul16(stc_ff.c0, -stc_ff.w);
      jl_in[1][1] = lmul16(stc_ff.s0, -stc_ff.w);
      jl_in[2][1] = stc_ff.j21;
      jl_in[0][2] = lmul16(stc_ff.c0, stc_ff.v);
      jl_in[1][2] = lmul16(stc_ff.s0, stc_ff.v);
      jl_in[2][2] = stc_ff.j22;
      jl_in[0][3] = lmul16(stc_ff.c0, stc_ff.u);
      jl_in[1][3] = lmul16(stc_ff.s0, stc_ff.u);
      jl_in[2][3] = stc_ff.j23;
      jl_in[0][4] = -(LW'(d6) * LW'(stc_ff.e04));
      jl_in[1][4] = LW'(d6) * LW'(stc_ff.e14);
      jl_in[2][4] = stc_ff.j24;
      jl_in[0][5] = '0;
      jl_in[1][5] = '0;
      jl_in[2][5] = '0;

      ja_in[0][0] = '0;
      ja_in[0][1] = JA_W'(stc_ff.s0);
      ja_in[0][2] = JA_W'(stc_ff.s0);
      ja_in[0][3] = JA_W'(stc_ff.s0);
      ja_in[0][4] = JA_W'(stc_ff.s123c0);
      ja_in[0][5] = JA_W'(stc_ff.e10);
      ja_in[1][0] = '0;
      ja_in[1][1] = -JA_W'(stc_ff.c0);
      ja_in[1][2] = -JA_W'(stc_ff.c0);
      ja_in[1][3] = -JA_W'(stc_ff.c0);
      ja_in[1][4] = JA_W'(stc_ff.s123s0);
      ja_in[1][5] = -JA_W'(stc_ff.e00);
      ja_in[2][0] = ONE_Q16;
      ja_in[2][1] = '0;
      ja_in[2][2] = '0;
      ja_in[2][3] = '0;
      ja_in[2][4] = -JA_W'(stc_ff.c123);
      ja_in[2][5] = -JA_W'(stc_ff.s123s4);
   end

   always_ff @(posedge clock) begin
      if (load[SD]) begin
         jl_ff <= jl_in;
         ja_ff <= ja_in;
      end
   end

   // ---------------- stage E: entry times joint rate
   logic signed [PL_W-1:0] pl_in [3][NUM_JOINTS];
   logic signed [PL_W-1:0] pl_ff [3][NUM_JOINTS];
   logic signed [PA_W-1:0] pa_in [3][NUM_JOINTS];
   logic signed [PA_W-1:0] pa_ff [3][NUM_JOINTS];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            pl_in[k][j] = PL_W'(jl_ff[k][j]) * PL_W'(wp_ff[SE-1][j]);
            pa_in[k][j] = PA_W'(ja_ff[k][j]) * PA_W'(wp_ff[SE-1][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[SE]) begin
         pl_ff <= pl_in;
         pa_ff <= pa_in;
      end
   end

   // ---------------- stage F: row sums
   logic signed [ACC_L_W-1:0] accl_in [3];
   logic signed [ACC_L_W-1:0] accl_ff [3];
   logic signed [ACC_A_W-1:0] acca_in [3];
   logic signed [ACC_A_W-1:0] acca_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         accl_in[k] = '0;
         acca_in[k] = '0;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            accl_in[k] = accl_in[k] + ACC_L_W'(pl_ff[k][j]);
            acca_in[k] = acca_in[k] + ACC_A_W'(pa_ff[k][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[SF]) begin
         accl_ff <= accl_in;
         acca_ff <= acca_in;
      end
   end

   // ---------------- stage G: round, saturate, output register
   logic signed [ACC_L_W-1:0] rl [3];
   logic signed [ACC_A_W-1:0] ra [3];
   logic signed [LIN_W-1:0]   lin_in [3];
   logic signed [LIN_W-1:0]   lin_ff [3];
   logic signed [ANG_W-1:0]   ang_in [3];
   logic signed [ANG_W-1:0]   ang_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rl[k] = (accl_ff[k] + (ACC_L_W'(1) <<< 25)) >>> 26;
         ra[k] = (acca_ff[k] + (ACC_A_W'(1) <<< 15)) >>> 16;
         if (rl[k][ACC_L_W-1:LIN_W-1] == '0 || rl[k][ACC_L_W-1:LIN_W-1] == '1) begin
            lin_in[k] = rl[k][LIN_W-1:0];
         end else begin
            lin_in[k] = rl[k][ACC_L_W-1] ? {1'b1, {(LIN_W-1){1'b0}}}
                                          : {1'b0, {(LIN_W-1){1'b1}}};
         end
         if (ra[k][ACC_A_W-1:ANG_W-1] == '0 || ra[k][ACC_A_W-1:ANG_W-1] == '1) begin
            ang_in[k] = ra[k][ANG_W-1:0];
         end else begin
            ang_in[k] = ra[k][ACC_A_W-1] ? {1'b1, {(ANG_W-1){1'b0}}}
                                          : {1'b0, {(ANG_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[SG]) begin
         lin_ff <= lin_in;
         ang_ff <= ang_in;
      end
   end

   assign rsp.valid     = valid_ff[NSTG-1];
   assign rsp.linear_x  = lin_ff[0];
   assign rsp.linear_y  = lin_ff[1];
   assign rsp.linear_z  = lin_ff[2];
   assign rsp.angular_x = ang_ff[0];
   assign rsp.angular_y = ang_ff[1];
   assign rsp.angular_z = ang_ff[2];

   // ---------------- checks
   // input side only backs up when the whole pipe is full and the output is stalled
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready)
      else $error("input stalled while pipeline has a bubble");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_idx == REG_FLANGE |=>
         len_ff[REG_FLANGE] == $past(csr_pwdata[LEN_W-1:0]))
      else $error("flange offset write lost");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import jtv_pkg::*;

   localparam int  LIMIT_CYCLES = 600000;
   localparam int  DRAIN_CYCLES = CORDIC_STAGES_DEF + 24;
   localparam int  LONG_HOLD    = 300;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED_LO = CSR_ADDR_W'(4 * NUM_REGS);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED_HI = CSR_ADDR_W'(4 * NUM_REGS + 4);

   typedef struct {
      logic signed [ANGLE_W-1:0] ang [NUM_JOINTS];
      logic signed [RATE_W-1:0]  rate[NUM_JOINTS];
   } joint_state_type;

   typedef struct {
      longint lin[3];
      longint rot[3];
   } tool_velocity_type;

   class tool_velocity_board;
      longint a2, a3, d2, d4, d5, d6;
      tool_velocity_type expected_q[$];
      int failures;
      longint atan_tab[24] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                               8385879, 4193963, 2097109, 1048571, 524287, 262144,
                               131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
                               512, 256, 128, 64, 32};

      function new();
         a2 = -15594; a3 = -13632; d2 = 7670; d4 = -605; d5 = 5338; d6 = 5274;
         failures = 0;
      endfunction

      function void set_length(int idx, logic [31:0] value);
         longint v;
         v = longint'($signed(value[LEN_W-1:0]));
         case (idx)
            REG_UPPER_ARM: a2 = v;
            REG_FOREARM:   a3 = v;
            REG_SHOULDER:  d2 = v;
            REG_WRIST_ONE: d4 = v;
            REG_WRIST_TWO: d5 = v;
            REG_FLANGE:    d6 = v;
            default: ;
         endcase
      endfunction

      function longint rnd(longint v, int n);
         return (v + (longint'(1) << (n - 1))) >>> n;
      endfunction

      function longint m16(longint a, longint b);
         return rnd(a * b, 16);
      endfunction

      function longint clamp(longint v, int w);
         longint hi, lo;
         hi = (longint'(1) << (w - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void sin_cos(longint a, output longint s, output longint c);
         longint r, x, y, nx, two_pi, pi, half_pi;
         bit neg;
         int stages;
         two_pi = longint'(TWO_PI_Q28);
         pi = longint'(PI_Q28);
         half_pi = longint'(HALF_PI_Q28);
         r = (a * 16384) % two_pi;
         x = longint'(CORDIC_GAIN_Q28);
         y = 0;
         neg = 0;
         stages = (CORDIC_STAGES_DEF > 24) ? 24 : CORDIC_STAGES_DEF;
         if (r > pi) r -= two_pi;
         else if (r < -pi) r += two_pi;
         if (r > half_pi) begin
            r = pi - r; neg = 1;
         end else if (r < -half_pi) begin
            r = -pi - r; neg = 1;
         end
         for (int i = 0; i < stages; i++) begin
            if (r >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); r -= atan_tab[i];
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); r += atan_tab[i];
            end
            x = nx;
         end
         c = neg ? -rnd(x, 12) : rnd(x, 12);
         s = rnd(y, 12);
      endfunction

      function void note_input(joint_state_type js);
         longint q[6], w[6], jl[3][6], ja[3][6];
         longint s0, c0, s1, c1, s12, c12, s123, c123, s4, c4;
         longint s0s4, c0c4, c0s4, c4s0, s123s4, c123s4, s123c4, wv, vv, uv, acc;
         tool_velocity_type tv;
         for (int j = 0; j < 6; j++) begin
            q[j] = longint'(js.ang[j]);
            w[j] = longint'(js.rate[j]);
         end
         sin_cos(q[0], s0, c0);
         sin_cos(q[1], s1, c1);
         sin_cos(q[1] + q[2], s12, c12);
         sin_cos(q[1] + q[2] + q[3], s123, c123);
         sin_cos(q[4], s4, c4);
         s0s4 = m16(s0, s4); c0c4 = m16(c0, c4); c0s4 = m16(c0, s4); c4s0 = m16(c4, s0);
         s123s4 = m16(s123, s4); c123s4 = m16(c123, s4); s123c4 = m16(s123, c4);

         jl[0][0] = d6 * (c0c4 + m16(c123, s0s4)) + (d2 + d4) * c0
                  - a3 * m16(c12, s0) - a2 * m16(c1, s0) - d5 * m16(s123, s0);
         jl[1][0] = d6 * (c4s0 - m16(c123, c0s4)) + (d2 + d4) * s0
                  + a3 * m16(c12, c0) + a2 * m16(c1, c0) + d5 * m16(s123, c0);
         jl[2][0] = 0;
         wv = a3 * s12 + a2 * s1 - d5 * c123 - d6 * s123s4;
         jl[0][1] = rnd(-c0 * wv, 16);
         jl[1][1] = rnd(-s0 * wv, 16);
         jl[2][1] = a3 * c12 + a2 * c1 + d5 * s123 - d6 * c123s4;
         vv = d5 * c123 - a3 * s12 + d6 * s123s4;
         jl[0][2] = rnd(c0 * vv, 16);
         jl[1][2] = rnd(s0 * vv, 16);
         jl[2][2] = a3 * c12 + d5 * s123 - d6 * c123s4;
         uv = d5 * c123 + d6 * s123s4;
         jl[0][3] = rnd(c0 * uv, 16);
         jl[1][3] = rnd(s0 * uv, 16);
         jl[2][3] = d5 * s123 - d6 * c123s4;
         jl[0][4] = -d6 * (s0s4 + m16(c123, c0c4));
         jl[1][4] = d6 * (c0s4 - m16(c123, c4s0));
         jl[2][4] = -d6 * s123c4;
         jl[0][5] = 0; jl[1][5] = 0; jl[2][5] = 0;

         ja[0][0] = 0; ja[0][1] = s0; ja[0][2] = s0; ja[0][3] = s0;
         ja[0][4] = m16(s123, c0);
         ja[0][5] = c4s0 - m16(c123, c0s4);
         ja[1][0] = 0; ja[1][1] = -c0; ja[1][2] = -c0; ja[1][3] = -c0;
         ja[1][4] = m16(s123, s0);
         ja[1][5] = -c0c4 - m16(c123, s0s4);
         ja[2][0] = 65536; ja[2][1] = 0; ja[2][2] = 0; ja[2][3] = 0;
         ja[2][4] = -c123;
         ja[2][5] = -s123s4;

         for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int j = 0; j < 6; j++) acc += jl[k][j] * w[j];
            tv.lin[k] = clamp(rnd(acc, 26), LIN_W);
            acc = 0;
            for (int j = 0; j < 6; j++) acc += ja[k][j] * w[j];
            tv.rot[k] = clamp(rnd(acc, 16), ANG_W);
         end
         expected_q = {expected_q, tv};
      endfunction

      function void check_result(tool_velocity_type got);
         tool_velocity_type exp_tv;
         string lin_names[3] = '{"linear_x", "linear_y", "linear_z"};
         string rot_names[3] = '{"angular_x", "angular_y", "angular_z"};
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected");
            failures++;
            return;
         end
         exp_tv = expected_q.pop_front();
         for (int k = 0; k < 3; k++) begin
            if (got.lin[k] != exp_tv.lin[k]) begin
               $error("%s: expected %0d, got %0d", lin_names[k], exp_tv.lin[k], got.lin[k]);
               failures++;
            end
            if (got.rot[k] != exp_tv.rot[k]) begin
               $error("%s: expected %0d, got %0d", rot_names[k], exp_tv.rot[k], got.rot[k]);
               failures++;
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic                  csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   jtv_req_if req_if ();
   jtv_rsp_if rsp_if ();

   jacobian_tool_velocity_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if.sink),
      .rsp         (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tool_velocity_board board = new();
   bit calm = 0;
   bit long_hold_req = 0;
   int cycle_count = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall bursts plus one long hold-off to back the pipeline up
   int hold_left = 0;
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 0;
      end else if (long_hold_req) begin
         long_hold_req = 0;
         hold_left = LONG_HOLD - 1;
         rsp_if.ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(1, 5) - 1;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= 1;
      end
   end

   always @(posedge clock) begin
      tool_velocity_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.lin[0] = longint'(rsp_if.linear_x);
         got.lin[1] = longint'(rsp_if.linear_y);
         got.lin[2] = longint'(rsp_if.linear_z);
         got.rot[0] = longint'(rsp_if.angular_x);
         got.rot[1] = longint'(rsp_if.angular_y);
         got.rot[2] = longint'(rsp_if.angular_z);
         board.check_result(got);
      end
   end

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.set_length(int'(addr >> 2), data);
   endtask

   task automatic load_lengths(int l0, int l1, int l2, int l3, int l4, int l5);
      // upper bits are junk on purpose, only the low 17 count
      csr_write({REG_UPPER_ARM, 2'b00}, {15'($urandom_range(0, 32767)), 17'(l0)});
      csr_write({REG_FOREARM,   2'b00}, {15'($urandom_range(0, 32767)), 17'(l1)});
      csr_write({REG_SHOULDER,  2'b00}, {15'($urandom_range(0, 32767)), 17'(l2)});
      csr_write({REG_WRIST_ONE, 2'b00}, {15'($urandom_range(0, 32767)), 17'(l3)});
      csr_write({REG_WRIST_TWO, 2'b00}, {15'($urandom_range(0, 32767)), 17'(l4)});
      csr_write({REG_FLANGE,    2'b00}, {15'($urandom_range(0, 32767)), 17'(l5)});
   endtask

   task automatic send_joints(joint_state_type js);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.joint1_angle <= js.ang[0]; req_if.joint2_angle <= js.ang[1];
      req_if.joint3_angle <= js.ang[2]; req_if.joint4_angle <= js.ang[3];
      req_if.joint5_angle <= js.ang[4]; req_if.joint6_angle <= js.ang[5];
      req_if.joint1_rate <= js.rate[0]; req_if.joint2_rate <= js.rate[1];
      req_if.joint3_rate <= js.rate[2]; req_if.joint4_rate <= js.rate[3];
      req_if.joint5_rate <= js.rate[4]; req_if.joint6_rate <= js.rate[5];
      do @(posedge clock); while (!req_if.ready);
      board.note_input(js);
   endtask

   function automatic joint_state_type uniform_joints(int a, int r);
      joint_state_type js;
      for (int j = 0; j < NUM_JOINTS; j++) begin
         js.ang[j]  = ANGLE_W'(a);
         js.rate[j] = RATE_W'(r);
      end
      return js;
   endfunction

   function automatic joint_state_type random_joints();
      joint_state_type js;
      int mode;
      mode = $urandom_range(0, 3);
      for (int j = 0; j < NUM_JOINTS; j++) begin
         js.ang[j] = ANGLE_W'($urandom);
         js.rate[j] = RATE_W'($urandom);
         // small values keep the outputs out of saturation
         if (mode == 0) begin
            js.ang[j] = ANGLE_W'($signed(16'($urandom)));
            js.rate[j] = RATE_W'($signed(14'($urandom)));
         end else if (mode == 1) begin
            js.rate[j] = RATE_W'($signed(12'($urandom)));
         end
      end
      return js;
   endfunction

   task automatic drain_and_settle();
      req_if.valid <= 0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_run(int n);
      for (int i = 0; i < n; i++) send_joints(random_joints());
      drain_and_settle();
   endtask

   initial begin
      joint_state_type js;
      req_if.valid <= 0;
      req_if.joint1_angle <= '0; req_if.joint2_angle <= '0; req_if.joint3_angle <= '0;
      req_if.joint4_angle <= '0; req_if.joint5_angle <= '0; req_if.joint6_angle <= '0;
      req_if.joint1_rate <= '0; req_if.joint2_rate <= '0; req_if.joint3_rate <= '0;
      req_if.joint4_rate <= '0; req_if.joint5_rate <= '0; req_if.joint6_rate <= '0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: zeros, field extremes, quadrant edges, large angle sums
      send_joints(uniform_joints(0, 0));
      send_joints(uniform_joints(262143, 262143));
      send_joints(uniform_joints(-262144, -262144));
      send_joints(uniform_joints(262143, -262144));
      send_joints(uniform_joints(-262144, 262143));
      send_joints(uniform_joints(51472, 16384));
      send_joints(uniform_joints(-51472, 16384));
      send_joints(uniform_joints(25736, -16384));
      send_joints(uniform_joints(25737, 16384));
      send_joints(uniform_joints(-25737, 16384));
      send_joints(uniform_joints(102944, 1));
      send_joints(uniform_joints(1, -1));
      for (int j = 0; j < NUM_JOINTS; j++) begin
         js = uniform_joints(12000, 0);
         js.rate[j] = RATE_W'(262143);
         send_joints(js);
      end
      js = uniform_joints(0, 4000);
      js.ang[1] = ANGLE_W'(262143); js.ang[2] = ANGLE_W'(262143);
      js.ang[3] = ANGLE_W'(262143);
      send_joints(js);
      js.ang[1] = ANGLE_W'(-262144); js.ang[2] = ANGLE_W'(-262144);
      js.ang[3] = ANGLE_W'(-262144);
      send_joints(js);
      drain_and_settle();

      // writes outside the register range must be dropped
      csr_write(ADDR_UNUSED_LO, 32'h0000_1234);
      csr_write(ADDR_UNUSED_HI, 32'hffff_ffff);
      long_hold_req = 1;
      random_run(200);

      load_lengths(65535, 65535, 65535, 65535, 65535, 65535);
      random_run(200);
      load_lengths(-65536, -65536, -65536, -65536, -65536, -65536);
      random_run(200);
      load_lengths(65535, -65536, 65535, -65536, 65535, -65536);
      random_run(150);
      load_lengths(0, 0, 0, 0, 0, 0);
      random_run(100);
      for (int p = 0; p < 3; p++) begin
         load_lengths($urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
                      $urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
                      $urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536);
         random_run(200);
      end
      load_lengths(-15594, -13632, 7670, -605, 5338, 5274);
      random_run(150);
      calm = 1;
      random_run(150);

      if (board.failures == 0 && board.expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
